/* rtl/tssc_pkg.sv */
// tssc_pkg: shared types and constants of the tdma slot synchronizer
// depends on nothing; imported by tdma_slot_sync_controller
`default_nettype none

package tssc_pkg;

  // neighbor table size, the index width that follows from it and the count width
  localparam int unsigned MaxNeighbors = 16;
  localparam int unsigned NbrIdxW      = (MaxNeighbors > 1) ? $clog2(MaxNeighbors) : 1;
  localparam int unsigned CntW         = 5;

  // configuration port
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgOwnAddress    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgSlotLength    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgSubcycleLen   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgCyclesFrame   = CfgIdxW'(3);

  // reset values of the registers
  localparam logic [7:0]  RstOwnAddress  = 8'd0;
  localparam logic [15:0] RstSlotLength  = 16'd1;
  localparam logic [15:0] RstSubcycleLen = 16'd1000;
  localparam logic [7:0]  RstCyclesFrame = 8'd8;

  // input word kinds
  localparam logic KindTick   = 1'b0;
  localparam logic KindPacket = 1'b1;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_RECEIVE = 2'd1,
    CMD_IDLE    = 2'd2
  } radio_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  sender_address;
    logic [7:0]  sender_cycle;
    logic [15:0] sender_time;
  } in_word_t;

  typedef struct packed {
    logic            send_packet;
    logic [7:0]      sent_cycle;
    logic [15:0]     sent_time;
    logic [1:0]      radio_command;
    logic [CntW-1:0] neighbor_count;
  } out_word_t;

endpackage

`default_nettype wire

/* rtl/tdma_slot_sync_controller.sv */
// tdma_slot_sync_controller: slot timer, cycle counter and neighbor table
// depends on tssc_pkg
`default_nettype none

// Takes one word at a time: a timer tick or a received call packet, and
// returns one result word for each. A tick is accepted in the idle state and
// computed in the tick state. A packet searches the neighbor memory one
// entry per cycle through its single read port, stopping at a match or
// after the last heard entry. A new word is accepted only once the
// previous one is finished; a finished result parks in the output
// register (or one holding register) while the receiver stalls. A
// configuration write applies to every word whose compute cycle follows
// the write edge.
module tdma_slot_sync_controller
  import tssc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // input words
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire in_word_t            in_data_i,
  // result words
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output out_word_t                out_data_o
);

  // configuration registers
  logic [7:0]  own_address_q;
  logic [15:0] slot_length_q;
  logic [15:0] subcycle_len_q;
  logic [7:0]  cycles_frame_q;
  logic [23:0] offset;

  // block state
  state_e          state_q, state_d;
  logic [15:0]     timer_q, timer_d;
  logic [7:0]      cycle_q, cycle_d;
  logic [CntW-1:0] hc_q, hc_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            pend_q, pend_d;
  in_word_t        in_q;
  out_word_t       res_q, res_d;
  out_word_t       out_q, out_d;
  logic            out_valid_q, out_valid_d;

  // neighbor memory
  logic [7:0]         nbr_mem [MaxNeighbors];
  logic [7:0]         rd_data_q;
  logic [NbrIdxW-1:0] rd_addr;
  logic               mem_we;
  logic [NbrIdxW-1:0] mem_waddr;

  // shared control
  logic       out_free;
  logic       fin;
  logic       rd_en;
  logic       match;
  logic [15:0] next_t;
  logic        wrap;
  logic [8:0]  cyc_inc;
  logic        frame_end;
  logic [7:0]  new_cycle;
  logic [15:0] new_timer;
  logic        hit;

  assign out_free = !out_valid_q || out_ready_i;
  assign rd_en    = (idx_q < hc_q);
  assign match    = pend_q && (rd_data_q == in_q.sender_address);
  assign rd_addr  = idx_q[NbrIdxW-1:0];

  // transmit offset from the current registers
  assign offset = 24'(own_address_q) * 24'(slot_length_q);

  // tick arithmetic
  assign next_t    = timer_q + 16'd1;
  assign wrap      = (next_t == subcycle_len_q);
  assign cyc_inc   = {1'b0, cycle_q} + 9'd1;
  assign frame_end = (cyc_inc >= {1'b0, cycles_frame_q});
  assign new_cycle = wrap ? (frame_end ? 8'd0 : cyc_inc[7:0]) : cycle_q;
  assign new_timer = wrap ? 16'd0 : next_t;
  assign hit       = ({8'd0, new_timer} == offset);

  // finish condition of the working states
  always_comb begin
    case (state_q)
      ST_TICK: fin = 1'b1;
      ST_SCAN: fin = match || !rd_en;
      default: fin = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_data_i.kind == KindPacket) ? ST_SCAN : ST_TICK;
        end
      end
      ST_TICK, ST_SCAN: begin
        if (fin) begin
          state_d = out_free ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    timer_d     = timer_q;
    cycle_d     = cycle_q;
    hc_d        = hc_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = hc_q[NbrIdxW-1:0];
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
      end
      ST_TICK: begin
        res_d = '0;
        timer_d = new_timer;
        cycle_d = new_cycle;
        if (wrap) begin
          res_d.radio_command = frame_end ? CMD_RECEIVE : CMD_IDLE;
          if (frame_end) begin
            hc_d = '0;
          end
        end
        if (hit) begin
          res_d.send_packet = 1'b1;
          res_d.sent_cycle  = new_cycle;
          res_d.sent_time   = new_timer;
          if (new_cycle == 8'd0) begin
            res_d.radio_command = CMD_RECEIVE;
          end
        end
        res_d.neighbor_count = hc_d;
      end
      ST_SCAN: begin
        if (fin) begin
          res_d = '0;
          // add the sender when not found and there is room
          if (!match && (hc_q < CntW'(MaxNeighbors))) begin
            mem_we = 1'b1;
            hc_d   = hc_q + CntW'(1);
          end
          // lower address takes over the schedule
          if (in_q.sender_address < own_address_q) begin
            cycle_d = in_q.sender_cycle;
            timer_d = in_q.sender_time;
          end
          res_d.neighbor_count = hc_d;
        end else begin
          idx_d  = idx_q + CntW'(1);
          pend_d = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase

    // a fresh result goes straight to the output when the slot is free
    if (fin && out_free) begin
      out_d       = res_d;
      out_valid_d = 1'b1;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q  <= RstOwnAddress;
      slot_length_q  <= RstSlotLength;
      subcycle_len_q <= RstSubcycleLen;
      cycles_frame_q <= RstCyclesFrame;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgOwnAddress:  own_address_q  <= cfg_wdata_i[7:0];
          CfgSlotLength:  slot_length_q  <= cfg_wdata_i;
          CfgSubcycleLen: subcycle_len_q <= cfg_wdata_i;
          CfgCyclesFrame: cycles_frame_q <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
    end
  end

  // control and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      timer_q     <= '0;
      cycle_q     <= '0;
      hc_q        <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      timer_q     <= timer_d;
      cycle_q     <= cycle_d;
      hc_q        <= hc_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    res_q <= res_d;
    out_q <= out_d;
  end

  // neighbor memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      nbr_mem[mem_waddr] <= in_q.sender_address;
    end
    rd_data_q <= nbr_mem[rd_addr];
  end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// tb_top: self-checking bench for tdma_slot_sync_controller
// depends on tssc_pkg and the controller rtl; tracks timer, cycle and neighbor set per word
`default_nettype none

module tb_top;
  import tssc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // quiet cycles after the last result: a packet may scan the whole table
  localparam int unsigned SettleCycles = MaxNeighbors + 4;
  localparam int unsigned WordsPerPhase = 128;
  localparam int unsigned RandomPhases  = 12;
  localparam int unsigned LongHold      = 300;
  // index past the register list, writes must be dropped
  localparam logic [CfgIdxW-1:0] CfgNoReg = CfgIdxW'(9);

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_word_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_word_t           out_data_o;

  tdma_slot_sync_controller uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // predictor copy of registers and state
  int unsigned own_addr = RstOwnAddress;
  int unsigned slot_len = RstSlotLength;
  int unsigned sub_len  = RstSubcycleLen;
  int unsigned frames   = RstCyclesFrame;
  int unsigned timer_q  = 0;
  int unsigned cycle_q  = 0;
  int unsigned heard_n  = 0;
  logic [7:0]  heard_tab [MaxNeighbors];

  in_word_t    word_backlog [$];
  out_word_t   status_due [$];
  int unsigned n_offered = 0;
  int unsigned n_taken = 0;
  int unsigned errors = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned stall_asks = 0;
  int unsigned stall_done = 0;
  int unsigned hold_left = 0;

  // one word through the slot schedule, returns the status it causes
  function automatic out_word_t sync_step(in_word_t w);
    out_word_t   r;
    int unsigned nxt;
    int unsigned offs;
    bit          known;
    r = '0;
    known = 1'b0;
    if (w.kind == KindPacket) begin
      for (int i = 0; i < heard_n; i++) begin
        if (heard_tab[i] == w.sender_address) known = 1'b1;
      end
      if (!known && heard_n < MaxNeighbors) begin
        heard_tab[heard_n] = w.sender_address;
        heard_n++;
      end
      // lower address wins sync
      if (w.sender_address < own_addr) begin
        cycle_q = w.sender_cycle;
        timer_q = w.sender_time;
      end
    end else begin
      nxt  = (timer_q + 1) & 32'hFFFF;
      offs = own_addr * slot_len;
      // subcycle end on exact match only
      if (nxt == sub_len) begin
        nxt = 0;
        if (cycle_q + 1 >= frames) begin
          cycle_q = 0;
          heard_n = 0;
          r.radio_command = CMD_RECEIVE;
        end else begin
          cycle_q++;
          r.radio_command = CMD_IDLE;
        end
      end
      timer_q = nxt;
      // own transmit slot
      if (nxt == offs) begin
        r.send_packet = 1'b1;
        r.sent_cycle  = cycle_q[7:0];
        r.sent_time   = nxt[15:0];
        if (cycle_q == 0) r.radio_command = CMD_RECEIVE;
      end
    end
    r.neighbor_count = heard_n[CntW-1:0];
    return r;
  endfunction

  function automatic void check_field(string what, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d got %0d", $time, what, want_v, got_v);
    end
  endfunction

  // input words taken and result words checked at the rising edge
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      status_due.push_back(sync_step(in_data_i));
      n_taken++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_due.size() == 0) begin
        errors++;
        $display("%0t ns: result word with none expected, expected nothing got %h",
                 $time, out_data_o);
      end else begin
        want = status_due.pop_front();
        check_field("send_packet", want.send_packet, out_data_o.send_packet);
        check_field("sent_cycle", want.sent_cycle, out_data_o.sent_cycle);
        check_field("sent_time", want.sent_time, out_data_o.sent_time);
        check_field("radio_command", want.radio_command, out_data_o.radio_command);
        check_field("neighbor_count", want.neighbor_count, out_data_o.neighbor_count);
      end
    end
  end

  // input driver, next word only once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && n_offered == n_taken) begin
      if (word_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_data_i  <= word_backlog.pop_front();
        in_valid_i <= 1'b1;
        n_offered++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result ready, with a long hold-off on request
  always @(negedge clk_i) begin
    if (stall_asks != stall_done) begin
      hold_left = LongHold;
      stall_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic queue_word(logic kind, int unsigned addr, int unsigned cyc, int unsigned tm);
    in_word_t w;
    w.kind           = kind;
    w.sender_address = addr[7:0];
    w.sender_cycle   = cyc[7:0];
    w.sender_time    = tm[15:0];
    word_backlog.push_back(w);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[CfgDataW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgOwnAddress:  own_addr = val & 32'hFF;
      CfgSlotLength:  slot_len = val & 32'hFFFF;
      CfgSubcycleLen: sub_len  = val & 32'hFFFF;
      CfgCyclesFrame: frames   = val & 32'hFF;
      default: ;
    endcase
  endtask

  task automatic apply_setting(int unsigned own, int unsigned slot, int unsigned sub,
                               int unsigned frm);
    cfg_write(CfgOwnAddress, own);
    cfg_write(CfgSlotLength, slot);
    cfg_write(CfgSubcycleLen, sub);
    cfg_write(CfgCyclesFrame, frm);
    repeat (2) @(negedge clk_i);
  endtask

  // all words sent and every status back, then let the block settle
  task automatic wait_drain();
    while (word_backlog.size() != 0 || n_offered != n_taken || status_due.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin
        tx_idle_pct = 26;
        rx_idle_pct = 75;
      end
      1: begin
        tx_idle_pct = 75;
        rx_idle_pct = 26;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
  endtask

  // one random setting followed by a burst of ticks and packets
  task automatic run_random_phase(int unsigned k);
    int unsigned own, slot, sub, frm, lo, hi;
    case (k)
      3: begin
        own = 2; slot = 1; sub = 12; frm = 255;
      end
      6: begin
        own = 1; slot = 65535; sub = 65535; frm = 2;
      end
      9: begin
        own = 0; slot = $urandom_range(1, 65535); sub = 1; frm = 1;
      end
      default: begin
        own  = (k % 4 == 2) ? $urandom_range(200, 255) : $urandom_range(0, 6);
        slot = $urandom_range(1, 3);
        sub  = own * slot + $urandom_range(1, 24);
        frm  = $urandom_range(1, 5);
      end
    endcase
    apply_setting(own, slot, sub, frm);
    set_idling(k * 3 / RandomPhases);
    lo = (own > 12) ? own - 12 : 0;
    hi = (lo + 24 > 255) ? 255 : lo + 24;
    for (int n = 0; n < WordsPerPhase; n++) begin
      if ($urandom_range(99) < 30)
        queue_word(KindPacket,
                   ($urandom_range(99) < 80) ? $urandom_range(lo, hi) : $urandom_range(255),
                   ($urandom_range(99) < 80) ? $urandom_range(0, frm) : $urandom_range(255),
                   ($urandom_range(99) < 85) ? $urandom_range(0, sub - 1)
                                             : $urandom_range(65535));
      else
        queue_word(KindTick, $urandom_range(255), $urandom_range(255), $urandom_range(65535));
    end
    // receiver stalls long while words keep coming
    if (k == 1) stall_asks++;
    wait_drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    set_idling(0);

    // reset settings: tick with sender fields set, packets at field extremes
    queue_word(KindTick, 255, 255, 65535);
    queue_word(KindPacket, 255, 255, 65535);
    queue_word(KindPacket, 0, 0, 0);
    queue_word(KindTick, 0, 0, 0);
    wait_drain();

    // forced timer above the subcycle length, forced cycle 255 at frame end
    apply_setting(200, 1, 20, 255);
    cfg_write(CfgNoReg, 16'hFFFF);
    queue_word(KindPacket, 5, 3, 65534);
    queue_word(KindTick, 0, 0, 0);
    queue_word(KindTick, 0, 0, 0);
    queue_word(KindTick, 0, 0, 0);
    queue_word(KindPacket, 199, 255, 19);
    queue_word(KindTick, 0, 0, 0);
    queue_word(KindPacket, 200, 7, 3);
    queue_word(KindPacket, 255, 7, 3);
    wait_drain();

    // wrap and own slot on the same tick
    apply_setting(0, 65535, 1, 1);
    queue_word(KindTick, 0, 0, 0);
    queue_word(KindTick, 0, 0, 0);
    queue_word(KindTick, 0, 0, 0);
    wait_drain();

    // transmit offset past 16 bits never fires
    apply_setting(255, 65535, 65535, 1);
    queue_word(KindPacket, 254, 7, 65533);
    queue_word(KindTick, 0, 0, 0);
    queue_word(KindTick, 0, 0, 0);
    wait_drain();

    for (int unsigned k = 0; k < RandomPhases; k++) run_random_phase(k);

    wait_drain();
    if (errors == 0 && status_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
